// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps
package scd_pkg;

	localparam int DENOM_REGS     = 6;
	localparam int NUM_DENOMS_DEF = 6;
	localparam int AMT_W          = 20;
	localparam int STOCK_W        = 16;
	localparam int DENOM_W        = 16;
	localparam int SLOT_W         = 3;
	localparam int DIV_CNT_W      = $clog2(AMT_W);
	localparam int PROD_W         = AMT_W + DENOM_W;

	localparam logic [STOCK_W-1:0] RESTOCK_STEP = STOCK_W'(10);
	localparam logic [STOCK_W-1:0] STOCK_MAX    = '1;

	typedef enum logic [1:0] {
		REQ_CHANGE  = 2'd0,
		REQ_RESTOCK = 2'd1,
		REQ_LOAD    = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		REG_DENOMS_IN_USE = 3'd0,
		REG_DENOM_0       = 3'd1,
		REG_DENOM_1       = 3'd2,
		REG_DENOM_2       = 3'd3,
		REG_DENOM_3       = 3'd4,
		REG_DENOM_4       = 3'd5,
		REG_DENOM_5       = 3'd6,
		REG_IGNORE_STOCK  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [SLOT_W-1:0]                   denoms_in_use;
		logic [DENOM_REGS-1:0][DENOM_W-1:0] denom;
		logic                                ignore_stock;
	} cfg_t;

	typedef struct packed {
		logic                restock;
		logic                load;
		logic [SLOT_W-1:0]   slot;
		logic [STOCK_W-1:0]  sval;
		logic                commit;
		logic                ignore_stock;
		logic                out_load;
		logic                out_shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/scd_cfg_regs.sv =====
`timescale 1ns / 1ps
module scd_cfg_regs
	import scd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	assign widx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.denoms_in_use <= 3'd6;
			cfg_q.denom[0]      <= 16'd50000;
			cfg_q.denom[1]      <= 16'd20000;
			cfg_q.denom[2]      <= 16'd10000;
			cfg_q.denom[3]      <= 16'd5000;
			cfg_q.denom[4]      <= 16'd2000;
			cfg_q.denom[5]      <= 16'd1000;
			cfg_q.ignore_stock  <= 1'b0;
		end else if (wr_en) begin
			unique case (widx)
				REG_DENOMS_IN_USE: cfg_q.denoms_in_use <= pwdata[SLOT_W-1:0];
				REG_DENOM_0:       cfg_q.denom[0] <= pwdata[DENOM_W-1:0];
				REG_DENOM_1:       cfg_q.denom[1] <= pwdata[DENOM_W-1:0];
				REG_DENOM_2:       cfg_q.denom[2] <= pwdata[DENOM_W-1:0];
				REG_DENOM_3:       cfg_q.denom[3] <= pwdata[DENOM_W-1:0];
				REG_DENOM_4:       cfg_q.denom[4] <= pwdata[DENOM_W-1:0];
				REG_DENOM_5:       cfg_q.denom[5] <= pwdata[DENOM_W-1:0];
				REG_IGNORE_STOCK:  cfg_q.ignore_stock <= pwdata[0];
				default:           cfg_q.ignore_stock <= cfg_q.ignore_stock;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (widx)
			REG_DENOMS_IN_USE: prdata = 32'(cfg_q.denoms_in_use);
			REG_DENOM_0:       prdata = 32'(cfg_q.denom[0]);
			REG_DENOM_1:       prdata = 32'(cfg_q.denom[1]);
			REG_DENOM_2:       prdata = 32'(cfg_q.denom[2]);
			REG_DENOM_3:       prdata = 32'(cfg_q.denom[3]);
			REG_DENOM_4:       prdata = 32'(cfg_q.denom[4]);
			REG_DENOM_5:       prdata = 32'(cfg_q.denom[5]);
			REG_IGNORE_STOCK:  prdata = 32'(cfg_q.ignore_stock);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== rtl/scd_cell.sv =====
`timescale 1ns / 1ps
module scd_cell
	import scd_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic               active,
	input  logic [DENOM_W-1:0] denom,
	input  logic               start_in,
	input  logic [AMT_W-1:0]   rem_in,
	output logic               start_out,
	output logic [AMT_W-1:0]   rem_out,
	input  logic [AMT_W-1:0]   sh_take_in,
	input  logic [STOCK_W-1:0] sh_stock_in,
	output logic [AMT_W-1:0]   sh_take_out,
	output logic [STOCK_W-1:0] sh_stock_out
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_DIV,
		C_CLAMP,
		C_SUB
	} cstate_t;

	cstate_t              state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [AMT_W-1:0]     dvd_q;
	logic [DENOM_W-1:0]   prem_q;
	logic [AMT_W-1:0]     rem_q;
	logic [AMT_W-1:0]     take_q;
	logic [AMT_W-1:0]     rem_out_q;
	logic                 done_q;
	logic [STOCK_W-1:0]   stock_q;
	logic [AMT_W-1:0]     sh_take_q;
	logic [STOCK_W-1:0]   sh_stock_q;

	logic [DENOM_W:0]     trial;
	logic                 fits;
	logic [DENOM_W:0]     prem_nx;
	logic [AMT_W-1:0]     stock_ext;
	logic [PROD_W-1:0]    prod;
	logic [STOCK_W:0]     restock_sum;

	// one restoring division step per cycle
	assign trial     = {prem_q, dvd_q[AMT_W-1]};
	assign fits      = trial >= {1'b0, denom};
	assign prem_nx   = fits ? (trial - {1'b0, denom}) : trial;
	assign stock_ext = AMT_W'(stock_q);
	assign prod      = PROD_W'(take_q) * PROD_W'(denom);
	assign restock_sum = {1'b0, stock_q} + {1'b0, RESTOCK_STEP};

	assign start_out    = done_q;
	assign rem_out      = rem_out_q;
	assign sh_take_out  = sh_take_q;
	assign sh_stock_out = sh_stock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start_in) begin
						if (!active || denom == '0) begin
							take_q    <= '0;
							rem_out_q <= rem_in;
							done_q    <= 1'b1;
						end else begin
							dvd_q   <= rem_in;
							rem_q   <= rem_in;
							prem_q  <= '0;
							cnt_q   <= '0;
							state_q <= C_DIV;
						end
					end
				end
				C_DIV: begin
					dvd_q  <= {dvd_q[AMT_W-2:0], fits};
					prem_q <= prem_nx[DENOM_W-1:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(AMT_W - 1)) begin
						state_q <= C_CLAMP;
					end
				end
				C_CLAMP: begin
					if (!ctrl.ignore_stock && dvd_q > stock_ext) begin
						take_q <= stock_ext;
					end else begin
						take_q <= dvd_q;
					end
					state_q <= C_SUB;
				end
				C_SUB: begin
					// take * denom never exceeds the remaining amount
					rem_out_q <= rem_q - prod[AMT_W-1:0];
					done_q    <= 1'b1;
					state_q   <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stock_q <= '0;
		end else begin
			priority if (ctrl.restock) begin
				stock_q <= restock_sum[STOCK_W] ? STOCK_MAX : restock_sum[STOCK_W-1:0];
			end else if (ctrl.load && ctrl.slot == SLOT_W'(IDX)) begin
				stock_q <= ctrl.sval;
			end else if (ctrl.commit) begin
				stock_q <= stock_q - take_q[STOCK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.out_load) begin
			sh_take_q  <= take_q;
			sh_stock_q <= stock_q;
		end else if (ctrl.out_shift) begin
			sh_take_q  <= sh_take_in;
			sh_stock_q <= sh_stock_in;
		end
	end

endmodule

// ===== rtl/stocked_change_dispenser.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                        Transfer
// s_*       in         tvalid tready tdata tuser      one request
// m_*       out        tvalid tready tdata tuser tlast one result per slot
// apb       in/out     psel penable pwrite paddr ...  one register write/read
//
// Change: a 20-step serial divide in the cell of each denomination in use,
// then clamp and multiply-subtract; an unused cell passes the remainder on.
// The result row is then loaded (S_LOAD) and one result goes out per cycle
// while m_tready is high. Restock also loads the result row before its
// results; load and unknown requests give one result. s_tready is high
// only when idle. Reset zeroes all stock and loads the default denominations.
module stocked_change_dispenser
	import scd_pkg::*;
#(
	parameter int NUM_DENOMS = NUM_DENOMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // amount_cents[19:0], slot[22:20], stock_value[38:23]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // slot_out[2:0], pieces[22:3], stock_left[38:23]
	output logic        m_tuser,   // ok
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NUM_CELLS = (NUM_DENOMS < DENOM_REGS) ? NUM_DENOMS : DENOM_REGS;
	localparam logic [SLOT_W-1:0] CELLS_L = SLOT_W'(NUM_CELLS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_LOAD,
		S_OUT,
		S_WAIT
	} state_t;

	cfg_t       cfg;
	cell_ctrl_t ctrl;

	state_t              state_q;
	logic [SLOT_W-1:0]   k_q;
	logic                ok_q;
	logic                show_take_q;
	logic                m_tvalid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [AMT_W-1:0]    out_pieces_q;
	logic [STOCK_W-1:0]  out_stock_q;
	logic                out_ok_q;
	logic                out_last_q;

	logic                accept;
	req_t                req;
	logic [AMT_W-1:0]    in_amount;
	logic [SLOT_W-1:0]   in_slot;
	logic [STOCK_W-1:0]  in_sval;
	logic [SLOT_W-1:0]   n_use;
	logic                slot_ok;
	logic                out_free;
	logic                tail_done;
	logic                exact;

	logic                start_c    [NUM_CELLS+1];
	logic [AMT_W-1:0]    rem_c      [NUM_CELLS+1];
	logic [AMT_W-1:0]    sh_take_c  [NUM_CELLS+1];
	logic [STOCK_W-1:0]  sh_stock_c [NUM_CELLS+1];
	logic [NUM_CELLS-1:0] active;

	scd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_amount = s_tdata[19:0];
	assign in_slot   = s_tdata[22:20];
	assign in_sval   = s_tdata[38:23];
	assign req       = req_t'(s_tuser);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_ok   = in_slot < CELLS_L;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		priority if (cfg.denoms_in_use == '0) begin
			n_use = SLOT_W'(1);
		end else if (cfg.denoms_in_use > CELLS_L) begin
			n_use = CELLS_L;
		end else begin
			n_use = cfg.denoms_in_use;
		end
	end

	assign tail_done = start_c[NUM_CELLS];
	assign exact     = rem_c[NUM_CELLS] == '0;

	always_comb begin
		ctrl              = '0;
		ctrl.ignore_stock = cfg.ignore_stock;
		ctrl.slot         = in_slot;
		ctrl.sval         = in_sval;
		ctrl.restock      = accept && req == REQ_RESTOCK;
		ctrl.load         = accept && req == REQ_LOAD && slot_ok;
		ctrl.commit       = state_q == S_RUN && tail_done && exact && !cfg.ignore_stock;
		ctrl.out_load     = state_q == S_LOAD;
		ctrl.out_shift    = state_q == S_OUT && out_free;
	end

	assign start_c[0]            = accept && req == REQ_CHANGE;
	assign rem_c[0]              = in_amount;
	assign sh_take_c[NUM_CELLS]  = '0;
	assign sh_stock_c[NUM_CELLS] = '0;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		assign active[i] = SLOT_W'(i) < n_use;

		scd_cell #(
			.IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.active       (active[i]),
			.denom        (cfg.denom[i]),
			.start_in     (start_c[i]),
			.rem_in       (rem_c[i]),
			.start_out    (start_c[i+1]),
			.rem_out      (rem_c[i+1]),
			.sh_take_in   (sh_take_c[i+1]),
			.sh_stock_in  (sh_stock_c[i+1]),
			.sh_take_out  (sh_take_c[i]),
			.sh_stock_out (sh_stock_c[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_tvalid_q  <= 1'b0;
			k_q         <= '0;
			ok_q        <= 1'b0;
			show_take_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_CHANGE: state_q <= S_RUN;
							REQ_RESTOCK: begin
								ok_q        <= 1'b1;
								show_take_q <= 1'b0;
								state_q     <= S_LOAD;
							end
							REQ_LOAD: begin
								m_tvalid_q   <= 1'b1;
								out_slot_q   <= in_slot;
								out_pieces_q <= '0;
								out_stock_q  <= slot_ok ? in_sval : '0;
								out_ok_q     <= slot_ok;
								out_last_q   <= 1'b1;
								state_q      <= S_WAIT;
							end
							default: begin
								m_tvalid_q   <= 1'b1;
								out_slot_q   <= '0;
								out_pieces_q <= '0;
								out_stock_q  <= '0;
								out_ok_q     <= 1'b0;
								out_last_q   <= 1'b1;
								state_q      <= S_WAIT;
							end
						endcase
					end
				end
				S_RUN: begin
					if (tail_done) begin
						ok_q        <= exact;
						show_take_q <= exact;
						state_q     <= S_LOAD;
					end
				end
				S_LOAD: begin
					k_q     <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_slot_q   <= k_q;
						out_pieces_q <= show_take_q ? sh_take_c[0] : '0;
						out_stock_q  <= sh_stock_c[0];
						out_ok_q     <= ok_q;
						out_last_q   <= k_q == n_use - 1'b1;
						k_q          <= k_q + 1'b1;
						if (k_q == n_use - 1'b1) begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_stock_q, out_pieces_q, out_slot_q};
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("request taken while a result is pending");

	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail_done |-> state_q == S_RUN)
		else $error("cell chain finished outside a change request");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not idle after the final result");

	a_fail_no_pieces: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tdata[22:3] == '0)
		else $error("pieces reported on a failed request");

endmodule

// ===== verif/tb_stocked_change_dispenser.sv =====
`timescale 1ns / 1ps
module tb_stocked_change_dispenser;
	import scd_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int SLOTS = (NUM_DENOMS_DEF < DENOM_REGS) ? NUM_DENOMS_DEF : DENOM_REGS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 50;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [AMT_W-1:0]   pieces;
		logic [STOCK_W-1:0] stock_left;
		logic               ok;
		logic               last;
	} payout_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	stocked_change_dispenser #(
		.NUM_DENOMS(NUM_DENOMS_DEF)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// register mirror and stock tracking
	logic [SLOT_W-1:0]  in_use_cfg = 3'd6;
	logic [DENOM_W-1:0] denom_cfg [DENOM_REGS] = '{16'd50000, 16'd20000, 16'd10000,
		16'd5000, 16'd2000, 16'd1000};
	logic               ignore_cfg = 1'b0;
	logic [STOCK_W-1:0] stock_count [DENOM_REGS] = '{default: '0};

	payout_t     pending_payouts [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_stall = 0;
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned in_use_count();
		if (in_use_cfg == 0) return 1;
		if (in_use_cfg > SLOTS) return SLOTS;
		return 32'(in_use_cfg);
	endfunction

	function automatic logic [31:0] reg_mirror(reg_idx_t idx);
		case (idx)
			REG_DENOMS_IN_USE: return {29'd0, in_use_cfg};
			REG_IGNORE_STOCK:  return {31'd0, ignore_cfg};
			default:           return {16'd0, denom_cfg[int'(idx) - 1]};
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void push_payout(int unsigned slot, int unsigned pieces,
		logic [STOCK_W-1:0] stock_left, logic ok, logic last);
		payout_t p;
		p.slot       = slot[SLOT_W-1:0];
		p.pieces     = pieces[AMT_W-1:0];
		p.stock_left = stock_left;
		p.ok         = ok;
		p.last       = last;
		pending_payouts.push_back(p);
	endfunction

	function automatic void compute_payout(logic [1:0] req, logic [AMT_W-1:0] amount,
		logic [SLOT_W-1:0] slot, logic [STOCK_W-1:0] sval);
		int unsigned n;
		int unsigned rem;
		int unsigned q;
		int unsigned take [DENOM_REGS];
		int unsigned v;
		logic        exact;
		n = in_use_count();
		case (req)
			REQ_CHANGE: begin
				rem = 32'(amount);
				for (int i = 0; i < n; i++) begin
					q = 0;
					if (denom_cfg[i] != 0) begin
						q = rem / denom_cfg[i];
						if (!ignore_cfg && q > stock_count[i]) q = 32'(stock_count[i]);
						rem -= q * denom_cfg[i];
					end
					take[i] = q;
				end
				exact = (rem == 0);
				for (int i = 0; i < n; i++) begin
					if (exact && !ignore_cfg) stock_count[i] -= take[i][STOCK_W-1:0];
					push_payout(i, exact ? take[i] : 0, stock_count[i], exact, i == n - 1);
				end
			end
			REQ_RESTOCK: begin
				for (int i = 0; i < SLOTS; i++) begin
					v = stock_count[i] + RESTOCK_STEP;
					stock_count[i] = (v > STOCK_MAX) ? STOCK_MAX : v[STOCK_W-1:0];
				end
				for (int i = 0; i < n; i++)
					push_payout(i, 0, stock_count[i], 1'b1, i == n - 1);
			end
			REQ_LOAD: begin
				if (slot < SLOTS) begin
					stock_count[slot] = sval;
					push_payout(slot, 0, sval, 1'b1, 1'b1);
				end else begin
					push_payout(slot, 0, '0, 1'b0, 1'b1);
				end
			end
			default: push_payout(0, 0, '0, 1'b0, 1'b1);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		payout_t got;
		payout_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.slot       = m_tdata[2:0];
			got.pieces     = m_tdata[22:3];
			got.stock_left = m_tdata[38:23];
			got.ok         = m_tuser;
			got.last       = m_tlast;
			if (pending_payouts.size() == 0) begin
				report_mismatch($sformatf("unexpected result slot=%0d pieces=%0d stock=%0d ok=%0b last=%0b",
					got.slot, got.pieces, got.stock_left, got.ok, got.last));
			end else begin
				want = pending_payouts.pop_front();
				if (got !== want)
					report_mismatch($sformatf({"exp slot=%0d pieces=%0d stock=%0d ok=%0b last=%0b",
						" / got slot=%0d pieces=%0d stock=%0d ok=%0b last=%0b"},
						want.slot, want.pieces, want.stock_left, want.ok, want.last,
						got.slot, got.pieces, got.stock_left, got.ok, got.last));
			end
		end
	end

	// result backpressure
	always @(posedge clk) begin
		if (!rx_idle_en) begin
			m_tready <= 1'b1;
		end else if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
			rx_stall <= pick_gap();
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)
			|| !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input logic [1:0] req, input logic [AMT_W-1:0] amount,
		input logic [SLOT_W-1:0] slot, input logic [STOCK_W-1:0] sval);
		int unsigned gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {1'b0, sval, slot, amount};
		do @(posedge clk); while (!s_tready);
		compute_payout(req, amount, slot, sval);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_payouts.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input reg_idx_t idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input reg_idx_t idx);
		logic [31:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== reg_mirror(idx))
			report_mismatch($sformatf("register %s read exp=%0h got=%0h",
				idx.name(), reg_mirror(idx), rd));
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] rd;
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, idx, value, rd);
		case (idx)
			REG_DENOMS_IN_USE: in_use_cfg = value[SLOT_W-1:0];
			REG_IGNORE_STOCK:  ignore_cfg = value[0];
			default:           denom_cfg[int'(idx) - 1] = value[DENOM_W-1:0];
		endcase
		check_register(idx);
	endtask

	task automatic apply_config(input logic [2:0] in_use, input logic [15:0] d0, d1, d2, d3,
		d4, d5, input logic ign);
		cfg_write(REG_DENOMS_IN_USE, 32'(in_use));
		cfg_write(REG_DENOM_0, 32'(d0));
		cfg_write(REG_DENOM_1, 32'(d1));
		cfg_write(REG_DENOM_2, 32'(d2));
		cfg_write(REG_DENOM_3, 32'(d3));
		cfg_write(REG_DENOM_4, 32'(d4));
		cfg_write(REG_DENOM_5, 32'(d5));
		cfg_write(REG_IGNORE_STOCK, 32'(ign));
	endtask

	// sums of whole pieces, so that greedy fills often succeed; some off by a little
	function automatic logic [AMT_W-1:0] payable_amount();
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < in_use_count(); i++) sum += $urandom_range(0, 3) * denom_cfg[i];
		if ($urandom_range(0, 4) == 0) sum += $urandom_range(1, 9);
		return sum[AMT_W-1:0];
	endfunction

	task automatic send_random_request();
		int unsigned         r;
		logic [AMT_W-1:0]    junk_amount;
		logic [SLOT_W-1:0]   junk_slot;
		logic [STOCK_W-1:0]  junk_val;
		logic [SLOT_W-1:0]   slot;
		logic [STOCK_W-1:0]  val;
		r = $urandom_range(0, 99);
		junk_amount = AMT_W'($urandom());
		junk_slot   = SLOT_W'($urandom());
		junk_val    = STOCK_W'($urandom());
		if (r < 55) begin
			send_req(REQ_CHANGE, ($urandom_range(0, 3) != 0) ? payable_amount() : junk_amount,
				junk_slot, junk_val);
		end else if (r < 65) begin
			send_req(REQ_RESTOCK, junk_amount, junk_slot, junk_val);
		end else if (r < 94) begin
			slot = SLOT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS, 7)
				: $urandom_range(0, SLOTS - 1));
			val = ($urandom_range(0, 4) == 0) ? junk_val : STOCK_W'($urandom_range(0, 12));
			send_req(REQ_LOAD, junk_amount, slot, val);
		end else begin
			send_req(REQ_UNKNOWN, junk_amount, junk_slot, junk_val);
		end
	endtask

	task automatic run_random(input int unsigned count);
		for (int i = 0; i < count; i++) send_random_request();
	endtask

	task automatic test_register_reset();
		for (int i = 0; i < 8; i++) check_register(reg_idx_t'(i));
	endtask

	task automatic test_directed();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_req(REQ_CHANGE, 20'd0, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'd1000, 3'd0, 16'd0);
		send_req(REQ_LOAD, 20'd0, 3'd0, 16'hFFFF);
		send_req(REQ_LOAD, 20'd0, 3'd1, 16'd0);
		send_req(REQ_LOAD, 20'd0, 3'd2, 16'd3);
		send_req(REQ_LOAD, 20'd0, 3'd3, 16'd1);
		send_req(REQ_LOAD, 20'd0, 3'd4, 16'd2);
		send_req(REQ_LOAD, 20'd0, 3'd5, 16'd5);
		send_req(REQ_LOAD, 20'd0, 3'd6, 16'hFFFF);
		send_req(REQ_LOAD, 20'hFFFFF, 3'd7, 16'h1234);
		send_req(REQ_UNKNOWN, 20'hFFFFF, 3'd7, 16'hFFFF);
		send_req(REQ_RESTOCK, 20'd0, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'd91000, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'hFFFFF, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'd1048000, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'd35000, 3'd0, 16'd0);
		cfg_write(REG_IGNORE_STOCK, 32'd1);
		send_req(REQ_CHANGE, 20'd1048000, 3'd0, 16'd0);
		send_req(REQ_CHANGE, 20'd999, 3'd0, 16'd0);
		send_req(REQ_RESTOCK, 20'hFFFFF, 3'd7, 16'hFFFF);
		send_req(REQ_LOAD, 20'd0, 3'd3, 16'd7);
		send_req(REQ_CHANGE, 20'd0, 3'd0, 16'd0);
		cfg_write(REG_IGNORE_STOCK, 32'd0);
		send_req(REQ_CHANGE, 20'd17000, 3'd0, 16'd0);
		wait_results_drained();
	endtask

	task automatic test_random_default();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_random(30);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		run_random(20);
		// hold off until the block has delivered everything
		wait_results_drained();
		run_random(50);
		wait_results_drained();
	endtask

	task automatic test_config_sweep();
		logic [15:0] d [DENOM_REGS];
		for (int k = 0; k < 5; k++) begin
			d[0] = 16'($urandom_range(1, 65535));
			for (int i = 1; i < DENOM_REGS; i++) d[i] = 16'($urandom_range(1, d[i-1]));
			case (k)
				0: apply_config(3'd1, 16'd1, d[1], d[2], d[3], d[4], d[5], 1'b0);
				1: apply_config(3'd7, 16'hFFFF, 16'd30000, 16'd0, 16'd500, 16'd7, 16'd1, 1'b1);
				2: apply_config(3'd0, 16'hFFFF, d[1], d[2], d[3], d[4], d[5], 1'b1);
				3: apply_config(3'd3, d[0], d[1], d[2], d[3], d[4], d[5], 1'b0);
				default: apply_config(3'd6, d[0], d[1], d[2], d[3], d[4], d[5],
					1'($urandom_range(0, 1)));
			endcase
			tx_idle_en = (k != 3);
			rx_idle_en = (k != 0);
			run_random(52);
			wait_results_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed();
		test_random_default();
		test_config_sweep();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
